### sv/bba_pkg.sv
package bba_pkg;

  localparam int LEVELS_DEF = 10;

  localparam logic [1:0] ST_EMPTY      = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_SPLIT_PART = 2'd2;
  localparam logic [1:0] ST_SPLIT_FULL = 2'd3;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  function automatic logic node_full(input logic [1:0] s);
    return (s == ST_FULL) || (s == ST_SPLIT_FULL);
  endfunction

  // Recompute a split node from its two children; two empty children merge.
  function automatic logic [1:0] node_refresh(input logic [1:0] l, input logic [1:0] r);
    logic [1:0] s;
    if (node_full(l) && node_full(r)) begin
      s = ST_SPLIT_FULL;
    end else if (l != ST_EMPTY || r != ST_EMPTY) begin
      s = ST_SPLIT_PART;
    end else begin
      s = ST_EMPTY;
    end
    return s;
  endfunction

endpackage

### sv/buddy_block_allocator.sv
// Binary buddy allocator over 2^LEVELS minimum blocks.
// Input channel (in_valid/in_stall): mode 0 allocates request_blocks
// (rounded up to a power of two, zero counts as one), mode 1 releases the
// leaf that covers release_block. A transfer happens when valid is high and
// stall is low.
// Output channel (out_valid/out_stall): one result per input, status 1 when
// an allocation found no space, block_offset the offset of the new block.
// The tree state sits in a single-port-read, single-port-write memory; a
// sequencer walks it one node at a time. Each node visited on the way down
// is read and then evaluated; each parent refreshed on the way up has its
// left child read, then its right child, and is then written; a split
// writes the high child in an extra step. When the low half of a node fails,
// the search moves on to its high half. The next transfer can be taken in
// the cycle after the result is loaded.
// in_stall is high while a request is being worked on.
// After reset an init step marks the root as one empty leaf; in_stall is
// high during it. A result waiting under out_stall holds its value; the
// next request is taken meanwhile but its result waits until the output
// register is free.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [10:0] request_blocks,
  input  logic [9:0]  release_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [9:0]  block_offset
);

  localparam int NW = LEVELS + 1;
  localparam int DW = $clog2(LEVELS + 1);
  localparam int AW = (LEVELS > 10) ? LEVELS : 10;
  localparam int SW = DW + 4;

  localparam logic [2:0] PH_INIT  = 3'd0;
  localparam logic [2:0] PH_IDLE  = 3'd1;
  localparam logic [2:0] PH_READ  = 3'd2;
  localparam logic [2:0] PH_EVAL  = 3'd3;
  localparam logic [2:0] PH_SPLIT = 3'd4;
  localparam logic [2:0] PH_UP    = 3'd5;
  localparam logic [2:0] PH_RDR   = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  logic [1:0]    mem [2**NW];
  logic [1:0]    mem_q;
  logic          rd_en;
  logic [NW-1:0] rd_addr;
  logic          wr_en;
  logic [NW-1:0] wr_addr;
  logic [1:0]    wr_data;

  logic [2:0]    phase;
  logic [NW-1:0] n;
  logic [DW-1:0] d;
  logic          op;
  logic [3:0]    ne;
  logic [AW-1:0] addr;
  logic          ok;
  logic [AW-1:0] res;
  logic [1:0]    left;
  logic          refresh_step;

  logic [3:0]    ne_next;
  logic [10:0]   req_m1;
  logic [SW-1:0] dn;
  logic [NW-1:0] n_low;
  logic [AW-1:0] addr_sh;
  logic          go_right;
  logic          accept;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_comb begin
    req_m1 = (request_blocks == 11'd0) ? 11'd0 : request_blocks - 11'd1;
    ne_next = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (req_m1[i]) begin
        ne_next = 4'(i + 1);
      end
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (phase != PH_IDLE);
  assign dn       = SW'(d) + SW'(ne);
  assign n_low    = (n & ~(NW'(1) << d)) << (LEVELS - int'(d));
  assign addr_sh  = addr >> (LEVELS - 1 - int'(d));
  assign go_right = ((addr >> LEVELS) != '0) || addr_sh[0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = n;
    wr_en   = 1'b0;
    wr_addr = n;
    wr_data = ST_EMPTY;
    unique case (phase)
      PH_INIT: begin
        wr_en   = 1'b1;
        wr_addr = NW'(1);
      end
      PH_READ: rd_en = 1'b1;
      PH_EVAL: begin
        if (op == MODE_ALLOC) begin
          if (mem_q == ST_EMPTY && dn < SW'(LEVELS)) begin
            wr_en   = 1'b1;
            wr_addr = n << 1;
          end else if (mem_q == ST_EMPTY && dn == SW'(LEVELS)) begin
            wr_en   = 1'b1;
            wr_data = ST_FULL;
          end
        end else if (!(mem_q[1] && d < DW'(LEVELS))) begin
          wr_en = 1'b1;
        end
      end
      PH_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = (n << 1) | NW'(1);
      end
      PH_UP: begin
        if (refresh_step) begin
          wr_en   = 1'b1;
          wr_data = node_refresh(left, mem_q);
        end else if (n != NW'(1) && !(op == MODE_ALLOC && !ok && !n[0])) begin
          rd_en   = 1'b1;
          rd_addr = n & ~NW'(1);
        end
      end
      PH_RDR: begin
        rd_en   = 1'b1;
        rd_addr = (n << 1) | NW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_INIT;
      out_valid    <= 1'b0;
      refresh_step <= 1'b0;
    end else begin
      if (out_valid && !out_stall && phase != PH_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (phase)
        PH_INIT: phase <= PH_IDLE;
        PH_IDLE: begin
          if (accept) begin
            n     <= NW'(1);
            d     <= '0;
            op    <= mode;
            ne    <= ne_next;
            addr  <= AW'(release_block);
            ok    <= 1'b0;
            res   <= '0;
            phase <= PH_READ;
          end
        end
        PH_READ: phase <= PH_EVAL;
        PH_EVAL: begin
          if (op == MODE_ALLOC) begin
            if (node_full(mem_q)) begin
              phase <= PH_UP;
            end else if (mem_q == ST_SPLIT_PART) begin
              if (d >= DW'(LEVELS)) begin
                phase <= PH_UP;
              end else begin
                n     <= n << 1;
                d     <= d + DW'(1);
                phase <= PH_READ;
              end
            end else if (dn > SW'(LEVELS)) begin
              phase <= PH_UP;
            end else if (dn < SW'(LEVELS)) begin
              phase <= PH_SPLIT;
            end else begin
              ok    <= 1'b1;
              res   <= AW'(n_low);
              phase <= PH_UP;
            end
          end else if (mem_q[1] && d < DW'(LEVELS)) begin
            n     <= go_right ? ((n << 1) | NW'(1)) : (n << 1);
            d     <= d + DW'(1);
            phase <= PH_READ;
          end else begin
            ok    <= 1'b1;
            phase <= PH_UP;
          end
        end
        PH_SPLIT: begin
          // descend into the fresh low half; it always fits
          n     <= n << 1;
          d     <= d + DW'(1);
          phase <= PH_READ;
        end
        PH_UP: begin
          if (refresh_step) begin
            refresh_step <= 1'b0;
          end else if (n == NW'(1)) begin
            phase <= PH_DONE;
          end else if (op == MODE_ALLOC && !ok && !n[0]) begin
            // low half failed: try the high half
            n     <= n + NW'(1);
            phase <= PH_READ;
          end else begin
            n     <= n >> 1;
            d     <= d - DW'(1);
            phase <= PH_RDR;
          end
        end
        PH_RDR: begin
          left         <= mem_q;
          refresh_step <= 1'b1;
          phase        <= PH_UP;
        end
        PH_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= (op == MODE_ALLOC) && !ok;
            block_offset <= (op == MODE_ALLOC && ok) ? res[9:0] : 10'd0;
            phase        <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> phase == PH_READ)
    else $error("accepted transfer did not start a walk");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> block_offset == 10'd0)
    else $error("failed allocation carries an offset");

  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    phase == PH_EVAL |-> $past(phase) == PH_READ)
    else $error("node evaluated without a read");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE && phase != PH_INIT |-> d <= DW'(LEVELS))
    else $error("depth past leaf level");

endmodule
